// ===== hdl/cfa_pkg.sv =====
// contiguous fit allocator: shared constants, cell layout, controller state,
// command and status structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

  localparam int unsigned CELL_COUNT = 1024;
  localparam int unsigned IDX_W      = $clog2(CELL_COUNT);
  localparam int unsigned LEN_W      = $clog2(CELL_COUNT + 1);
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned OWNER_W    = 16;
  localparam int unsigned START_W    = 10;
  localparam int unsigned POL_W      = 2;
  localparam int unsigned CMP_W      = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef logic [CMP_W-1:0] cmp_t;

  typedef struct packed {
    logic               held;
    logic [OWNER_W-1:0] owner;
  } cell_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH,
    ST_CHOOSE,
    ST_WRITE,
    ST_CLEAR,
    ST_CDRAIN,
    ST_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic init_wr;
    logic cnt_clr;
    logic cnt_inc;
    logic rd_en;
    logic load_req;
    logic flush;
    logic wr_load;
    logic alloc_wr;
    logic res_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_clear;
    logic in_size_zero;
    logic addr_last;
    logic found;
    logic rem_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/cfa_req_if.sv =====
// request channel: valid/ready handshake with allocate or clear payload
// depends on cfa_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface cfa_req_if;
  import cfa_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [OWNER_W-1:0] owner_id;
  logic [SIZE_W-1:0]  alloc_size;

  modport source (output valid, output mode, output owner_id, output alloc_size,
                  input ready);
  modport sink   (input valid, input mode, input owner_id, input alloc_size,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/cfa_rsp_if.sv =====
// response channel: valid/ready handshake with success and start index
// depends on cfa_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface cfa_rsp_if;
  import cfa_pkg::*;

  logic               valid;
  logic               ready;
  logic               success;
  logic [START_W-1:0] start_index;

  modport source (output valid, output success, output start_index, input ready);
  modport sink   (input valid, input success, input start_index, output ready);
endinterface

`default_nettype wire

// ===== hdl/contiguous_fit_allocator.sv =====
// contiguous fit allocator top level: joins controller and datapath to the ports
// depends on cfa_pkg, cfa_req_if, cfa_rsp_if, cfa_ctrl, cfa_dpath
//
//   channel    dir   handshake      payload
//   req_i      in    valid/ready    mode, owner_id, alloc_size
//   rsp_o      out   valid/ready    success, start_index
//   cfg        in    cfg_we_i       cfg_wdata_i (fit_policy)
//
// sequencing: one request at a time; clear and allocate walk the ownership
//   memory one cell a cycle through its single read port, a placed allocate
//   then writes alloc_size cells, and a zero-size allocate skips the walk
// reset: a sweep writes every cell free; no beat is taken on req_i until it
//   ends, config writes are taken throughout
// stalls: the result sits in its own register, so a held rsp_o only stops
//   the next request at its final step
`timescale 1ns / 1ps
`default_nettype none

module contiguous_fit_allocator
  import cfa_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  cfa_req_if.sink          req_i,
  cfa_rsp_if.source        rsp_o,
  input  wire              cfg_we_i,
  input  wire  [POL_W-1:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // controller: owns the sequencing, sees only status and the request valid
  cfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  assign req_i.ready = in_ready;

  // datapath: memory, run tracker and result beat register
  cfa_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_mode_i     (req_i.mode),
    .in_owner_i    (req_i.owner_id),
    .in_size_i     (req_i.alloc_size),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .out_success_o (rsp_o.success),
    .out_start_o   (rsp_o.start_index)
  );

endmodule

`default_nettype wire

// ===== hdl/cfa_ctrl.sv =====
// allocator controller: sequences reset sweep, scan, placement write and clear
// depends on cfa_pkg (state_e, cmd_t, sts_t)
`timescale 1ns / 1ps
`default_nettype none

module cfa_ctrl
  import cfa_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sts_i.addr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.in_clear)          state_d = ST_CLEAR;
          else if (sts_i.in_size_zero) state_d = ST_RESP;
          else                         state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.addr_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_FLUSH;
      ST_FLUSH:  state_d = ST_CHOOSE;
      ST_CHOOSE: begin
        state_d = sts_i.found ? ST_WRITE : ST_RESP;
      end
      ST_WRITE: begin
        if (sts_i.rem_last) state_d = ST_RESP;
      end
      ST_CLEAR: begin
        if (sts_i.addr_last) state_d = ST_CDRAIN;
      end
      ST_CDRAIN: state_d = ST_RESP;
      ST_RESP: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.cnt_clr  = 1'b1;
        end
      end
      ST_SCAN, ST_CLEAR: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_DRAIN, ST_CDRAIN: begin
      end
      ST_FLUSH: cmd_o.flush = 1'b1;
      ST_CHOOSE: begin
        if (sts_i.found) cmd_o.wr_load = 1'b1;
      end
      ST_WRITE: cmd_o.alloc_wr = 1'b1;
      ST_RESP: begin
        if (sts_i.out_free) cmd_o.res_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/cfa_dpath.sv =====
// allocator datapath: ownership memory, scan counters, run tracker, result register
// depends on cfa_pkg (cell_t, cmd_t, sts_t, widths)
`timescale 1ns / 1ps
`default_nettype none

module cfa_dpath
  import cfa_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  wire                in_mode_i,
  input  wire  [OWNER_W-1:0] in_owner_i,
  input  wire  [SIZE_W-1:0]  in_size_i,
  input  wire                cfg_we_i,
  input  wire  [POL_W-1:0]   cfg_wdata_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic               out_success_o,
  output logic [START_W-1:0] out_start_o
);

  cell_t mem [CELL_COUNT];
  cell_t rd_data_q;

  logic [POL_W-1:0]   policy_q;
  logic               mode_q;
  logic [OWNER_W-1:0] owner_q;
  logic [SIZE_W-1:0]  size_q;

  logic [IDX_W-1:0]   addr_q;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;

  logic [IDX_W-1:0]   run_start_q, run_start_d;
  logic [LEN_W-1:0]   run_len_q, run_len_d;
  logic [IDX_W-1:0]   best_start_q, best_start_d;
  logic [LEN_W-1:0]   best_len_q, best_len_d;
  logic               found_q, found_d;

  logic [IDX_W-1:0]   wr_addr_q;
  logic [SIZE_W-1:0]  rem_q;

  logic               out_valid_q;
  logic               out_success_q;
  logic [START_W-1:0] out_start_q;

  logic               step_en, is_free, fits, take;
  logic               clr_hit;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  cell_t              mem_wd;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIRST;
    end else if (cfg_we_i) begin
      policy_q <= cfg_wdata_i;
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      mode_q  <= in_mode_i;
      owner_q <= in_owner_i;
      size_q  <= in_size_i;
    end
  end

  // sweep counter and read pipeline tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.cnt_clr)      addr_q <= '0;
      else if (cmd_i.cnt_inc) addr_q <= addr_q + IDX_W'(1);
      rd_vld_q <= cmd_i.rd_en;
      rd_idx_q <= addr_q;
    end
  end

  // run tracking, one cell per cycle plus a closing flush step
  assign step_en = (rd_vld_q && (mode_q == MODE_ALLOC)) || cmd_i.flush;
  assign is_free = rd_vld_q && !rd_data_q.held;
  assign fits    = cmp_t'(run_len_q) >= cmp_t'(size_q);

  always_comb begin
    take = 1'b0;
    if (!found_q)                    take = 1'b1;
    else if (policy_q == POL_BEST)   take = run_len_q < best_len_q;
    else if (policy_q == POL_WORST)  take = run_len_q > best_len_q;
  end

  always_comb begin
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    found_d      = found_q;
    if (cmd_i.load_req) begin
      run_start_d  = '0;
      run_len_d    = '0;
      best_start_d = '0;
      best_len_d   = '0;
      found_d      = 1'b0;
    end else if (step_en) begin
      if (is_free) begin
        if (run_len_q == '0) run_start_d = rd_idx_q;
        run_len_d = run_len_q + LEN_W'(1);
      end else begin
        if (fits && take) begin
          found_d      = 1'b1;
          best_start_d = run_start_q;
          best_len_d   = run_len_q;
        end
        run_len_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_start_q  <= run_start_d;
    run_len_q    <= run_len_d;
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
  end

  // placement write counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_load) begin
      wr_addr_q <= best_start_q;
      rem_q     <= size_q;
    end else if (cmd_i.alloc_wr) begin
      wr_addr_q <= wr_addr_q + IDX_W'(1);
      rem_q     <= rem_q - SIZE_W'(1);
    end
  end

  // memory write port select
  assign clr_hit = rd_vld_q && (mode_q == MODE_CLEAR) && rd_data_q.held &&
                   (rd_data_q.owner == owner_q);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = '0;
    if (cmd_i.init_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.alloc_wr) begin
      mem_we       = 1'b1;
      mem_wa       = wr_addr_q;
      mem_wd.held  = 1'b1;
      mem_wd.owner = owner_q;
    end else if (clr_hit) begin
      mem_we = 1'b1;
      mem_wa = rd_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_q <= mem[addr_q];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      if (mode_q == MODE_CLEAR) begin
        out_success_q <= 1'b1;
        out_start_q   <= '0;
      end else begin
        out_success_q <= found_q;
        out_start_q   <= found_q ? START_W'(best_start_q) : '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_success_o = out_success_q;
  assign out_start_o   = out_start_q;

  assign sts_o.in_clear     = (in_mode_i == MODE_CLEAR);
  assign sts_o.in_size_zero = (in_size_i == '0);
  assign sts_o.addr_last    = (addr_q == IDX_W'(CELL_COUNT - 1));
  assign sts_o.found        = found_q;
  assign sts_o.rem_last     = (rem_q == SIZE_W'(1));
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== tb/cfa_alloc_checker.sv =====
// allocation checker: watches the request, response and policy ports, keeps its
// own ownership map and compares every response beat with the predicted outcome
// depends on cfa_pkg, cfa_req_if, cfa_rsp_if
`timescale 1ns / 1ps

module cfa_alloc_checker
  import cfa_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  cfa_req_if               req_mon,
  cfa_rsp_if               rsp_mon,
  input  wire              cfg_we_i,
  input  wire  [POL_W-1:0] cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               placed_o,
  output int               refused_o
);

  typedef struct packed {
    logic               success;
    logic [START_W-1:0] start_index;
  } outcome_t;

  cell_t            cell_map [CELL_COUNT];
  logic [POL_W-1:0] placement;
  outcome_t         outcome_q [$];
  int               rsp_beats;

  function automatic void note_fault(input string text);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("[%0t] response %0d: %s", $time, rsp_beats, text);
    end
  endfunction

  // applies one request to the map and returns the response it should give
  function automatic outcome_t serve_request(input logic mode,
                                             input logic [OWNER_W-1:0] who,
                                             input logic [SIZE_W-1:0] size);
    outcome_t    res;
    int unsigned idx;
    int unsigned run_begin;
    int unsigned run_len;
    int unsigned pick_begin;
    int unsigned pick_len;
    logic        found;
    logic        take;
    logic        is_free;
    res        = '0;
    found      = 1'b0;
    take       = 1'b0;
    run_begin  = 0;
    run_len    = 0;
    pick_begin = 0;
    pick_len   = 0;
    if (mode == MODE_CLEAR) begin
      for (idx = 0; idx < CELL_COUNT; idx++) begin
        if (cell_map[idx].held && cell_map[idx].owner == who) cell_map[idx] = '0;
      end
      res.success = 1'b1;
      return res;
    end
    if (size == '0) return res;
    // one cell past the end closes the last run
    for (idx = 0; idx <= CELL_COUNT; idx++) begin
      is_free = (idx < CELL_COUNT) && !cell_map[idx].held;
      if (is_free) begin
        if (run_len == 0) run_begin = idx;
        run_len++;
      end else begin
        if (run_len >= size) begin
          if (!found) take = 1'b1;
          else if (placement == POL_BEST) take = (run_len < pick_len);
          else if (placement == POL_WORST) take = (run_len > pick_len);
          else take = 1'b0;
          if (take) begin
            found      = 1'b1;
            pick_begin = run_begin;
            pick_len   = run_len;
          end
        end
        run_len = 0;
      end
    end
    if (found) begin
      for (idx = pick_begin; idx < pick_begin + size && idx < CELL_COUNT; idx++) begin
        cell_map[idx] = '{held: 1'b1, owner: who};
      end
      res.success     = 1'b1;
      res.start_index = pick_begin[START_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : monitor
    outcome_t want;
    outcome_t seen;
    int       idx;
    if (!rst_ni) begin
      for (idx = 0; idx < CELL_COUNT; idx++) cell_map[idx] = '0;
      placement = POL_FIRST;
      outcome_q.delete();
      fail_count_o = 0;
      placed_o     = 0;
      refused_o    = 0;
      rsp_beats    = 0;
    end else begin
      if (cfg_we_i) placement = cfg_wdata_i;
      if (rsp_mon.valid && rsp_mon.ready) begin
        seen.success     = rsp_mon.success;
        seen.start_index = rsp_mon.start_index;
        if (outcome_q.size() == 0) begin
          note_fault($sformatf("no request outstanding, got success %0b start %0d",
                               seen.success, seen.start_index));
        end else begin
          want = outcome_q.pop_front();
          if (seen.success !== want.success) begin
            note_fault($sformatf("success expected %0b, got %0b",
                                 want.success, seen.success));
          end
          if (seen.start_index !== want.start_index) begin
            note_fault($sformatf("start_index expected %0d, got %0d",
                                 want.start_index, seen.start_index));
          end
        end
        rsp_beats++;
      end
      if (req_mon.valid && req_mon.ready) begin
        want = serve_request(req_mon.mode, req_mon.owner_id, req_mon.alloc_size);
        if (req_mon.mode == MODE_ALLOC) begin
          if (want.success) placed_o++;
          else refused_o++;
        end
        outcome_q.push_back(want);
      end
    end
    pending_o = outcome_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// top of the allocator testbench: clock, reset, request and policy stimulus,
// response back-pressure, watchdog and verdict
// depends on cfa_pkg, cfa_req_if, cfa_rsp_if, cfa_alloc_checker, contiguous_fit_allocator
`timescale 1ns / 1ps

module testbench;
  import cfa_pkg::*;

  // policy code three has no name in the package, it behaves as first fit
  localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

  // a request walks the whole map once and then writes up to its size
  localparam int DRAIN_CYCLES = 2 * CELL_COUNT + 16;
  // long response hold-off, long enough for the next request to stall at its final step behind it
  localparam int HOLD_CYCLES  = 6000;
  // cycles without any beat before the run is declared stuck
  localparam int STALL_LIMIT  = 40000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [POL_W-1:0] cfg_wdata;

  cfa_req_if req_ch ();
  cfa_rsp_if rsp_ch ();

  int fail_count;
  int pending;
  int placed;
  int refused;

  // idling switch for both sides, and the one-shot long hold-off request
  bit gaps_on;
  bit hold_armed;

  int sent;
  int clears;

  logic [OWNER_W-1:0] owner_pool [8];

  contiguous_fit_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  cfa_alloc_checker alloc_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .placed_o     (placed),
    .refused_o    (refused)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one request beat; valid stays high into the next call unless a gap is drawn
  task automatic offer_request(input logic m, input logic [OWNER_W-1:0] who,
                               input logic [SIZE_W-1:0] sz);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= m;
    req_ch.owner_id   <= who;
    req_ch.alloc_size <= sz;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
    if (m == MODE_CLEAR) clears++;
  endtask

  // mostly pool owners so that clears free real blocks and holes form;
  // stray owners only take a few cells so the map never silts up for good
  task automatic offer_random_request();
    logic               m;
    logic [OWNER_W-1:0] who;
    logic [SIZE_W-1:0]  sz;
    bit                 stray;
    int                 roll;
    m     = ($urandom_range(0, 99) < 28) ? MODE_CLEAR : MODE_ALLOC;
    stray = ($urandom_range(0, 6) == 0);
    who   = stray ? OWNER_W'($urandom) : owner_pool[$urandom_range(0, 7)];
    roll  = $urandom_range(0, 99);
    if (m == MODE_CLEAR) sz = SIZE_W'($urandom);
    else if (stray) sz = SIZE_W'($urandom_range(1, 4));
    else if (roll < 3) sz = '0;
    else if (roll < 6) sz = SIZE_W'($urandom_range(1024, 2047));
    else if (roll < 14) sz = SIZE_W'($urandom_range(65, 400));
    else sz = SIZE_W'($urandom_range(1, 64));
    offer_request(m, who, sz);
  endtask

  // sender goes quiet until every response is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_policy(input logic [POL_W-1:0] pol);
    cfg_we    <= 1'b1;
    cfg_wdata <= pol;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [POL_W-1:0] pol, input int items, input bit gaps);
    wait_drained();
    @(negedge clk);
    write_policy(pol);
    gaps_on = gaps;
    repeat (items) offer_random_request();
  endtask

  // response side: random ready bursts, plus one long hold-off on request
  initial begin : rsp_ready_gen
    bit hold_taken;
    hold_taken   = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  // stuck detector: any beat on either channel restarts the count
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
             STALL_LIMIT, pending);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int k;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_ALLOC;
    req_ch.owner_id   = '0;
    req_ch.alloc_size = '0;
    gaps_on           = 1'b1;
    hold_armed        = 1'b0;
    sent              = 0;
    clears            = 0;
    // owner zero and the all-ones owner are ordinary owners, keep both in play
    owner_pool[0] = '0;
    owner_pool[1] = '1;
    for (k = 2; k < 8; k++) owner_pool[k] = OWNER_W'($urandom);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, first fit on a freshly swept map
    write_policy(POL_FIRST);
    offer_request(MODE_ALLOC, owner_pool[0], 11'd1);
    offer_request(MODE_ALLOC, owner_pool[1], 11'd1);
    offer_request(MODE_ALLOC, 16'h1234, 11'd0);       // zero size is refused
    offer_request(MODE_ALLOC, 16'h1234, 11'd1024);    // no run that long left
    offer_request(MODE_ALLOC, 16'h1234, 11'd2047);    // beyond the map
    offer_request(MODE_CLEAR, 16'h5555, 11'd0);       // owner with nothing held
    offer_request(MODE_CLEAR, owner_pool[1], 11'h7ff);
    offer_request(MODE_CLEAR, owner_pool[0], 11'd5);  // must not free idle cells
    offer_request(MODE_ALLOC, 16'haaaa, 11'd1024);    // whole map in one go
    offer_request(MODE_ALLOC, 16'h5555, 11'd1);       // map full
    offer_request(MODE_CLEAR, 16'haaaa, 11'd0);
    // carve holes of five and three cells ahead of the large tail run
    offer_request(MODE_ALLOC, owner_pool[2], 11'd10);
    offer_request(MODE_ALLOC, owner_pool[3], 11'd5);
    offer_request(MODE_ALLOC, owner_pool[4], 11'd20);
    offer_request(MODE_ALLOC, owner_pool[5], 11'd3);
    offer_request(MODE_ALLOC, owner_pool[6], 11'd8);
    offer_request(MODE_CLEAR, owner_pool[3], 11'd0);
    offer_request(MODE_CLEAR, owner_pool[5], 11'd0);
    offer_request(MODE_ALLOC, owner_pool[7], 11'd3);
    // remaining holes under the other placements
    wait_drained();
    @(negedge clk);
    write_policy(POL_BEST);
    offer_request(MODE_ALLOC, owner_pool[2], 11'd2);
    offer_request(MODE_ALLOC, owner_pool[4], 11'd3);
    wait_drained();
    @(negedge clk);
    write_policy(POL_WORST);
    offer_request(MODE_ALLOC, owner_pool[6], 11'd4);
    wait_drained();
    @(negedge clk);
    write_policy(POL_SPARE);
    offer_request(MODE_ALLOC, owner_pool[7], 11'd1);

    // random phases; the first one opens with the long response hold-off
    // while requests keep coming, so the block fills and refuses input
    wait_drained();
    hold_armed = 1'b1;
    run_phase(POL_BEST, 45, 1'b1);
    run_phase(POL_WORST, 45, 1'b1);
    run_phase(POL_SPARE, 40, 1'b0);
    run_phase(POL_FIRST, 45, 1'b1);
    run_phase(POL_WORST, 45, 1'b1);
    // closing stretch without any idling
    run_phase(POL_BEST, 47, 1'b0);

    wait_drained();
    // room for any stray response after the last expected one
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests (%0d clears): %0d allocations placed, %0d refused",
             sent, clears, placed, refused);
    $display("under first, best, worst and spare policy codes, with a long response hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cfa_pkg.sv
hdl/cfa_req_if.sv
hdl/cfa_rsp_if.sv
hdl/cfa_ctrl.sv
hdl/cfa_dpath.sv
hdl/contiguous_fit_allocator.sv
tb/cfa_alloc_checker.sv
tb/testbench.sv
